[rtl/ptc_pkg.sv]
// Shared types, widths and command encodings for the pressure/temperature compensation block.
`timescale 1ns / 1ps
package ptc_pkg;

    localparam int RawW  = 20;
    localparam int CfgW  = 48;
    localparam int CfgIw = 2;
    localparam int AW    = 65;
    localparam int BW    = 17;
    localparam int PW    = AW + BW;
    localparam int AccW  = 100;
    localparam int ShW   = 7;
    localparam int DW    = 21;
    localparam int NW    = 58;
    localparam int AaW   = 25;
    localparam int NumW  = 76;
    localparam int DenW  = 80;
    localparam int DivBits = NumW + 32;
    localparam int QW    = 42;
    localparam int PmW   = 41;
    localparam int SqW   = 81;
    localparam int TcW   = 16;
    localparam int PresW = 32;

    localparam logic [CfgIw-1:0] CFG_TEMP    = 2'd0;
    localparam logic [CfgIw-1:0] CFG_PRESS_A = 2'd1;
    localparam logic [CfgIw-1:0] CFG_PRESS_B = 2'd2;
    localparam logic [CfgIw-1:0] CFG_PRESS_C = 2'd3;

    typedef enum logic [3:0] {
        A_ONE, A_D, A_DD, A_A, A_A2, A_E, A_Q, A_DM, A_GM, A_PM, A_SQLO, A_SQHI, A_P8S
    } t_asel;

    typedef enum logic [4:0] {
        B_ONE, B_K6250, B_DLO, B_DHI, B_ALO, B_AHI, B_H0, B_H1, B_H2,
        B_T2, B_T3, B_P1U, B_P2, B_P3, B_P4, B_P5, B_P6, B_P7, B_P8, B_P9
    } t_bsel;

    typedef enum logic [3:0] {
        ST_NONE, ST_DD, ST_N, ST_A, ST_A2, ST_E, ST_G, ST_DIFF, ST_NUM, ST_DEN,
        ST_P8, ST_SQ, ST_PRES, ST_HOLD
    } t_store;

    typedef struct packed {
        logic           load;
        logic           mul_en;
        t_asel          a_sel;
        t_bsel          b_sel;
        logic [ShW-1:0] sh;
        logic           clr;
        logic           neg;
        t_store         st;
        logic           div_start;
        logic           div_step;
        logic           out_load;
    } t_cmd;

    typedef struct packed {
        logic den_zero;
    } t_stat;

endpackage

[rtl/ptc_div.sv]
// Restoring divider, one quotient bit per cycle while i_step is high, rounded and clamped quotient.
`timescale 1ns / 1ps
module ptc_div (
    input  logic                     i_clk,
    input  logic                     i_start,
    input  logic                     i_step,
    input  logic [ptc_pkg::NumW-1:0] i_num,
    input  logic [ptc_pkg::DenW-1:0] i_den,
    output logic [ptc_pkg::PmW-1:0]  o_pm
);
    import ptc_pkg::*;

    logic [DivBits-1:0] r_sh;
    logic [DenW-1:0]    r_rem;
    logic [QW-1:0]      r_quo;
    logic               r_ovf;

    logic [DenW:0]      rem2;
    logic               ge;
    logic [DenW:0]      rem_sub;
    logic               rnd;
    logic [QW:0]        qr;

    assign rem2    = {r_rem, r_sh[DivBits-1]};
    assign ge      = rem2 >= {1'b0, i_den};
    assign rem_sub = rem2 - {1'b0, i_den};
    assign rnd     = {r_rem, 1'b0} >= {1'b0, i_den};
    assign qr      = {1'b0, r_quo} + (QW+1)'(rnd);

    always_comb begin
        if (r_ovf || qr > ((QW+1)'(1) << (PmW-1))) begin
            o_pm = PmW'(1) << (PmW-1);
        end else begin
            o_pm = qr[PmW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= {i_num, 32'd0};
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (i_step) begin
            r_sh  <= {r_sh[DivBits-2:0], 1'b0};
            r_rem <= ge ? rem_sub[DenW-1:0] : rem2[DenW-1:0];
            r_quo <= {r_quo[QW-2:0], ge};
            r_ovf <= r_ovf | r_quo[QW-1];
        end
    end

endmodule

[rtl/ptc_datapath.sv]
// Datapath: coefficient registers, shared multiply-accumulate, divider and result registers.
`timescale 1ns / 1ps
module ptc_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ptc_pkg::CfgIw-1:0]    i_cfg_index,
    input  logic [ptc_pkg::CfgW-1:0]     i_cfg_data,
    input  logic [ptc_pkg::RawW-1:0]     i_raw_temperature,
    input  logic [ptc_pkg::RawW-1:0]     i_raw_pressure,
    input  ptc_pkg::t_cmd                i_cmd,
    output ptc_pkg::t_stat               o_stat,
    output logic signed [ptc_pkg::TcW-1:0] o_temperature_centi,
    output logic [ptc_pkg::PresW-1:0]    o_pressure_q24_8,
    output logic                         o_pressure_valid
);
    import ptc_pkg::*;

    logic [CfgW-1:0] r_tcf, r_pca, r_pcb, r_pcc;

    logic signed [DW-1:0]   r_d;
    logic [DW-1:0]          r_q;
    logic [40:0]            r_dd;
    logic signed [NW-1:0]   r_n;
    logic signed [AaW-1:0]  r_a;
    logic signed [TcW-1:0]  r_tc;
    logic [47:0]            r_a2;
    logic signed [AW-1:0]   r_e;
    logic [63:0]            r_gm;
    logic                   r_gneg;
    logic [63:0]            r_dm;
    logic                   r_dneg;
    logic [NumW-1:0]        r_num;
    logic [DenW-1:0]        r_den;
    logic [PmW-1:0]         r_pm;
    logic signed [PmW:0]    r_p8s;
    logic [SqW-1:0]         r_sq;
    logic [PresW-1:0]       r_res;
    logic                   r_res_valid;
    logic [PresW-1:0]       r_held;

    logic signed [PW-1:0]   r_prod;
    logic                   r_acc_en, r_clr, r_neg;
    logic [ShW-1:0]         r_sh;
    logic signed [AccW-1:0] r_acc;

    logic signed [AW-1:0]   a_op;
    logic signed [BW-1:0]   b_op;
    logic signed [AccW-1:0] term_sh, term, acc_base;
    logic [PmW-1:0]         div_pm;

    logic [NW-2:0]          n_mag;
    logic [60:0]            t5;
    logic [18:0]            tm;
    logic signed [TcW-1:0]  tc_new;
    logic [22:0]            tf_mag;
    logic signed [AaW-1:0]  a_new;
    logic [AccW-1:0]        acc_mag;
    logic [AccW-1:0]        psum;
    logic [PresW-1:0]       pres_new;

    // coefficient fields
    logic [15:0] t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = r_tcf[15:0];
    assign t2 = r_tcf[31:16];
    assign t3 = r_tcf[47:32];
    assign p1 = r_pca[15:0];
    assign p2 = r_pca[31:16];
    assign p3 = r_pca[47:32];
    assign p4 = r_pcb[15:0];
    assign p5 = r_pcb[31:16];
    assign p6 = r_pcb[47:32];
    assign p7 = r_pcc[15:0];
    assign p8 = r_pcc[31:16];
    assign p9 = r_pcc[47:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcf <= '0;
            r_pca <= '0;
            r_pcb <= '0;
            r_pcc <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TEMP:    r_tcf <= i_cfg_data;
                CFG_PRESS_A: r_pca <= i_cfg_data;
                CFG_PRESS_B: r_pcb <= i_cfg_data;
                CFG_PRESS_C: r_pcc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.a_sel)
            A_ONE:   a_op = AW'(1);
            A_D:     a_op = AW'(r_d);
            A_DD:    a_op = AW'({1'b0, r_dd});
            A_A:     a_op = AW'(r_a);
            A_A2:    a_op = AW'({1'b0, r_a2});
            A_E:     a_op = r_e;
            A_Q:     a_op = AW'({1'b0, r_q});
            A_DM:    a_op = AW'({1'b0, r_dm});
            A_GM:    a_op = AW'({1'b0, r_gm});
            A_PM:    a_op = AW'({1'b0, r_pm});
            A_SQLO:  a_op = AW'({1'b0, r_sq[63:0]});
            A_SQHI:  a_op = AW'({1'b0, r_sq[SqW-1:64]});
            A_P8S:   a_op = AW'(r_p8s);
            default: a_op = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.b_sel)
            B_ONE:   b_op = BW'(1);
            B_K6250: b_op = BW'(6250);
            B_DLO:   b_op = {1'b0, r_d[15:0]};
            B_DHI:   b_op = BW'(signed'(r_d[DW-1:16]));
            B_ALO:   b_op = {1'b0, r_a[15:0]};
            B_AHI:   b_op = BW'(signed'(r_a[AaW-1:16]));
            B_H0:    b_op = {1'b0, r_pm[15:0]};
            B_H1:    b_op = {1'b0, r_pm[31:16]};
            B_H2:    b_op = BW'({1'b0, r_pm[PmW-1:32]});
            B_T2:    b_op = BW'(t2);
            B_T3:    b_op = BW'(t3);
            B_P1U:   b_op = {1'b0, p1};
            B_P2:    b_op = BW'(p2);
            B_P3:    b_op = BW'(p3);
            B_P4:    b_op = BW'(p4);
            B_P5:    b_op = BW'(p5);
            B_P6:    b_op = BW'(p6);
            B_P7:    b_op = BW'(p7);
            B_P8:    b_op = BW'(p8);
            B_P9:    b_op = BW'(p9);
            default: b_op = '0;
        endcase
    end

    assign term_sh  = AccW'(r_prod) <<< r_sh;
    assign term     = r_neg ? -term_sh : term_sh;
    assign acc_base = r_clr ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.mul_en;
        end
        r_prod <= a_op * b_op;
        r_clr  <= i_cmd.clr;
        r_neg  <= i_cmd.neg;
        r_sh   <= i_cmd.sh;
        if (r_acc_en) begin
            r_acc <= acc_base + term;
        end
    end

    // temperature and fine temperature from N
    always_comb begin
        n_mag  = r_n[NW-1] ? (NW-1)'(-r_n) : r_n[NW-2:0];
        t5     = (61'(n_mag) << 2) + 61'(n_mag) + (61'd1 << 41);
        tm     = t5[60:42];
        tf_mag = n_mag[NW-2:34];
        if (r_n[NW-1]) begin
            tc_new = (tm > 19'd32768) ? 16'sh8000 : TcW'(19'd0 - tm);
            a_new  = -AaW'({1'b0, tf_mag}) - AaW'(128000);
        end else begin
            tc_new = (tm > 19'd32767) ? 16'sh7fff : tm[TcW-1:0];
            a_new  = AaW'({1'b0, tf_mag}) - AaW'(128000);
        end
    end

    always_comb begin
        acc_mag = r_acc[AccW-1] ? AccW'(-r_acc) : AccW'(r_acc);
        psum    = AccW'(r_acc) + (AccW'(1) << 42);
        if (r_acc[AccW-1]) begin
            pres_new = '0;
        end else if (|psum[AccW-1:75]) begin
            pres_new = '1;
        end else begin
            pres_new = psum[74:43];
        end
    end

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_start (i_cmd.div_start),
        .i_step  (i_cmd.div_step),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_pm    (div_pm)
    );

    assign o_stat.den_zero = (r_den == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.st == ST_PRES) begin
            r_held <= pres_new;
        end
        if (i_cmd.load) begin
            r_d <= DW'({1'b0, i_raw_temperature}) - DW'({1'b0, t1, 4'd0});
            r_q <= DW'(1 << RawW) - DW'({1'b0, i_raw_pressure});
        end
        case (i_cmd.st)
            ST_DD:   r_dd <= r_acc[40:0];
            ST_N:    r_n  <= r_acc[NW-1:0];
            ST_A: begin
                r_a  <= a_new;
                r_tc <= tc_new;
            end
            ST_A2:   r_a2 <= r_acc[47:0];
            ST_E:    r_e  <= r_acc[AW-1:0];
            ST_G: begin
                r_gm   <= acc_mag[63:0];
                r_gneg <= r_acc[AccW-1];
            end
            ST_DIFF: begin
                r_dm   <= acc_mag[63:0];
                r_dneg <= r_acc[AccW-1];
            end
            ST_NUM:  r_num <= r_acc[NumW-1:0];
            ST_DEN:  r_den <= r_acc[DenW-1:0];
            ST_P8: begin
                r_pm  <= div_pm;
                r_p8s <= (r_dneg ^ r_gneg) ? -(PmW+1)'({1'b0, div_pm})
                                           : (PmW+1)'({1'b0, div_pm});
            end
            ST_SQ:   r_sq <= r_acc[SqW-1:0];
            ST_PRES: begin
                r_res       <= pres_new;
                r_res_valid <= 1'b1;
            end
            ST_HOLD: begin
                r_res       <= r_held;
                r_res_valid <= 1'b0;
            end
            default: ;
        endcase
        if (i_cmd.out_load) begin
            o_temperature_centi <= r_tc;
            o_pressure_q24_8    <= r_res;
            o_pressure_valid    <= r_res_valid;
        end
    end

endmodule

[rtl/ptc_ctrl.sv]
// Controller: microcode sequencer for the compensation datapath and the beat handshakes.
`timescale 1ns / 1ps
module ptc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  ptc_pkg::t_stat i_stat,
    output ptc_pkg::t_cmd  o_cmd
);
    import ptc_pkg::*;

    localparam int PreLast  = 33;
    localparam int PostLast = 11;
    localparam int StepW    = 6;
    localparam int CntW     = $clog2(DivBits + 1);

    typedef enum logic [2:0] { S_IDLE, S_PRE, S_DIV, S_POST, S_FIN } t_state;

    t_state            r_state, n_state;
    logic [StepW-1:0]  r_step, n_step;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    function automatic t_cmd mop(t_asel a, t_bsel b, int sh, logic clr, logic neg);
        t_cmd c;
        c        = '0;
        c.mul_en = 1'b1;
        c.a_sel  = a;
        c.b_sel  = b;
        c.sh     = ShW'(sh);
        c.clr    = clr;
        c.neg    = neg;
        return c;
    endfunction

    function automatic t_cmd sto(t_store s);
        t_cmd c;
        c    = '0;
        c.st = s;
        return c;
    endfunction

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: o_cmd.load = i_in_valid;
            S_PRE: begin
                case (r_step)
                    6'd0:  o_cmd = mop(A_D,   B_DLO, 0,  1'b1, 1'b0);
                    6'd1:  o_cmd = mop(A_D,   B_DHI, 16, 1'b0, 1'b0);
                    6'd3:  o_cmd = sto(ST_DD);
                    6'd4:  o_cmd = mop(A_D,   B_T2,  20, 1'b1, 1'b0);
                    6'd5:  o_cmd = mop(A_DD,  B_T3,  0,  1'b0, 1'b0);
                    6'd7:  o_cmd = sto(ST_N);
                    6'd8:  o_cmd = sto(ST_A);
                    6'd9:  o_cmd = mop(A_A,   B_ALO, 0,  1'b1, 1'b0);
                    6'd10: o_cmd = mop(A_A,   B_AHI, 16, 1'b0, 1'b0);
                    6'd12: o_cmd = sto(ST_A2);
                    6'd13: o_cmd = mop(A_A2,  B_P6,  0,  1'b1, 1'b0);
                    6'd14: o_cmd = mop(A_A,   B_P5,  17, 1'b0, 1'b0);
                    6'd15: o_cmd = mop(A_ONE, B_P4,  35, 1'b0, 1'b0);
                    6'd17: o_cmd = sto(ST_E);
                    6'd18: o_cmd = mop(A_ONE, B_ONE, 55, 1'b1, 1'b0);
                    6'd19: o_cmd = mop(A_A2,  B_P3,  0,  1'b0, 1'b0);
                    6'd20: o_cmd = mop(A_A,   B_P2,  20, 1'b0, 1'b0);
                    6'd22: o_cmd = sto(ST_G);
                    6'd23: o_cmd = mop(A_Q,   B_ONE, 31, 1'b1, 1'b0);
                    6'd24: o_cmd = mop(A_E,   B_ONE, 0,  1'b0, 1'b1);
                    6'd26: o_cmd = sto(ST_DIFF);
                    6'd27: o_cmd = mop(A_DM,  B_K6250, 0, 1'b1, 1'b0);
                    6'd29: o_cmd = sto(ST_NUM);
                    6'd30: o_cmd = mop(A_GM,  B_P1U, 0,  1'b1, 1'b0);
                    6'd32: o_cmd = sto(ST_DEN);
                    6'd33: begin
                        if (i_stat.den_zero) begin
                            o_cmd = sto(ST_HOLD);
                        end else begin
                            o_cmd.div_start = 1'b1;
                        end
                    end
                    default: o_cmd = '0;
                endcase
            end
            S_DIV: begin
                if (r_cnt == CntW'(DivBits)) begin
                    o_cmd = sto(ST_P8);
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_POST: begin
                case (r_step)
                    6'd0:  o_cmd = mop(A_PM,   B_H0,  0,  1'b1, 1'b0);
                    6'd1:  o_cmd = mop(A_PM,   B_H1,  16, 1'b0, 1'b0);
                    6'd2:  o_cmd = mop(A_PM,   B_H2,  32, 1'b0, 1'b0);
                    6'd4:  o_cmd = sto(ST_SQ);
                    6'd5:  o_cmd = mop(A_SQLO, B_P9,  0,  1'b1, 1'b0);
                    6'd6:  o_cmd = mop(A_SQHI, B_P9,  64, 1'b0, 1'b0);
                    6'd7:  o_cmd = mop(A_P8S,  B_P8,  24, 1'b0, 1'b0);
                    6'd8:  o_cmd = mop(A_P8S,  B_ONE, 43, 1'b0, 1'b0);
                    6'd9:  o_cmd = mop(A_ONE,  B_P7,  47, 1'b0, 1'b0);
                    6'd11: o_cmd = sto(ST_PRES);
                    default: o_cmd = '0;
                endcase
            end
            S_FIN: o_cmd.out_load = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PRE;
                    n_step  = '0;
                end
            end
            S_PRE: begin
                if (r_step == StepW'(PreLast)) begin
                    n_cnt   = '0;
                    n_state = i_stat.den_zero ? S_FIN : S_DIV;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DIV: begin
                if (r_cnt == CntW'(DivBits)) begin
                    n_state = S_POST;
                    n_step  = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_POST: begin
                if (r_step == StepW'(PostLast)) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/pressure_temp_compensation_top.sv]
// Top level of the barometric pressure and temperature compensation block.
//
//  channel  | handshake                    | beat payload
//  ---------+------------------------------+-------------------------------------------
//  in       | i_in_valid / o_in_stall      | i_raw_temperature, i_raw_pressure
//  out      | o_out_valid / i_out_stall    | o_temperature_centi, o_pressure_q24_8,
//           |                              | o_pressure_valid
//  cfg      | i_cfg_we, i_cfg_index        | i_cfg_data (48 bits)
//
// Once an input beat is accepted, a result is offered after 34 microcode steps on the
// shared multiply-accumulate unit, the bit-serial divider (108 quotient bits, then the
// quotient store), 12 more steps, and the output load, which waits while the output is
// stalled. The next input beat is taken the cycle after that load. A zero divisor skips the
// divider and the final steps. Reset is synchronous, active low.
// The output register holds a stalled result while the next beat runs; its load waits for it.
`timescale 1ns / 1ps
module pressure_temp_compensation_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ptc_pkg::CfgIw-1:0]      i_cfg_index,
    input  logic [ptc_pkg::CfgW-1:0]       i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ptc_pkg::RawW-1:0]       i_raw_temperature,
    input  logic [ptc_pkg::RawW-1:0]       i_raw_pressure,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [ptc_pkg::TcW-1:0] o_temperature_centi,
    output logic [ptc_pkg::PresW-1:0]      o_pressure_q24_8,
    output logic                           o_pressure_valid
);
    import ptc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ptc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ptc_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_raw_temperature   (i_raw_temperature),
        .i_raw_pressure      (i_raw_pressure),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_q24_8    (o_pressure_q24_8),
        .o_pressure_valid    (o_pressure_valid)
    );

endmodule

[verif/pressure_temp_compensation_top_tb.sv]
// Self-checking testbench for pressure_temp_compensation_top: directed and random beats.
`timescale 1ns / 1ps
module pressure_temp_compensation_top_tb;
    import ptc_pkg::*;

    typedef logic signed [255:0] t_wide;
    typedef struct {
        logic [RawW-1:0] rt;
        logic [RawW-1:0] rp;
    } t_raw_pair;
    typedef struct {
        logic signed [TcW-1:0] tc;
        logic [PresW-1:0]      pres;
        logic                  pv;
    } t_reading;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CfgIw-1:0]      i_cfg_index;
    logic [CfgW-1:0]       i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [RawW-1:0]       i_raw_temperature;
    logic [RawW-1:0]       i_raw_pressure;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic signed [TcW-1:0] o_temperature_centi;
    logic [PresW-1:0]      o_pressure_q24_8;
    logic                  o_pressure_valid;

    pressure_temp_compensation_top dut (.*);

    logic [CfgW-1:0]  coef_t, coef_a, coef_b, coef_c;
    logic [PresW-1:0] held_pres;
    t_raw_pair        raw_backlog[$];
    t_reading         readings_due[$];
    int               mismatches;
    int               in_gap;
    int               out_hold;
    bit               calm;

    function automatic t_reading compensate(logic [RawW-1:0] rt, logic [RawW-1:0] rp);
        t_wide one, adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8c, p9;
        t_wide d, n, m, tm, tf, a, a2, e, g, diff, num, den, q, r, pm, p8s, s;
        t_reading res;
        one = t_wide'(1);
        adc_t = t_wide'(rt);
        adc_p = t_wide'(rp);
        t1 = t_wide'(coef_t[15:0]);
        t2 = t_wide'($signed(coef_t[31:16]));
        t3 = t_wide'($signed(coef_t[47:32]));
        p1 = t_wide'(coef_a[15:0]);
        p2 = t_wide'($signed(coef_a[31:16]));
        p3 = t_wide'($signed(coef_a[47:32]));
        p4 = t_wide'($signed(coef_b[15:0]));
        p5 = t_wide'($signed(coef_b[31:16]));
        p6 = t_wide'($signed(coef_b[47:32]));
        p7 = t_wide'($signed(coef_c[15:0]));
        p8c = t_wide'($signed(coef_c[31:16]));
        p9 = t_wide'($signed(coef_c[47:32]));
        d = adc_t - 16 * t1;
        n = d * t2 * (one <<< 20) + d * d * t3;
        m = n < 0 ? -n : n;
        tm = (m * 5 + (one <<< 41)) >>> 42;
        if (n < 0) begin
            res.tc = tm > 32768 ? 16'h8000 : 16'(-tm);
        end else begin
            res.tc = tm > 32767 ? 16'h7fff : 16'(tm);
        end
        tf = m >>> 34;
        if (n < 0) begin
            tf = -tf;
        end
        a = tf - 128000;
        a2 = a * a;
        e = a2 * p6 + a * p5 * (one <<< 17) + p4 * (one <<< 35);
        g = (one <<< 55) + a2 * p3 + a * p2 * (one <<< 20);
        if (p1 == 0 || g == 0) begin
            res.pres = held_pres;
            res.pv = 1'b0;
        end else begin
            diff = (1048576 - adc_p) * (one <<< 31) - e;
            num = ((diff < 0 ? -diff : diff) * 6250) <<< 32;
            den = p1 * (g < 0 ? -g : g);
            q = num / den;
            r = num % den;
            if (2 * r >= den) begin
                q = q + 1;
            end
            pm = q > (one <<< 40) ? (one <<< 40) : q;
            p8s = ((diff < 0) != (g < 0)) ? -pm : pm;
            s = p8s * (one <<< 43) + p9 * pm * pm + p8c * p8s * (one <<< 24) + p7 * (one <<< 47);
            if (s < 0) begin
                res.pres = '0;
            end else begin
                s = (s + (one <<< 42)) >>> 43;
                res.pres = s > (one <<< 32) - 1 ? 32'hffff_ffff : 32'(s);
            end
            res.pv = 1'b1;
            held_pres = res.pres;
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [CfgW-1:0] pack3(logic [15:0] lo, logic [15:0] mid, logic [15:0] hi);
        return {hi, mid, lo};
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // input side: acceptance and prediction
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            readings_due.push_back(compensate(i_raw_temperature, i_raw_pressure));
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || !o_in_stall)) begin
            if (i_in_valid) begin
                in_gap = pick_gap();
            end
            if (in_gap > 0 || raw_backlog.size() == 0) begin
                if (in_gap > 0) in_gap--;
                i_in_valid <= 1'b0;
            end else begin
                t_raw_pair it;
                it = raw_backlog.pop_front();
                i_raw_temperature <= it.rt;
                i_raw_pressure <= it.rp;
                i_in_valid <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            out_hold--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (!calm && $urandom_range(0, 99) < 8) begin
                out_hold = $urandom_range(0, 99) < 80 ? $urandom_range(1, 4)
                                                      : $urandom_range(20, 300);
            end
        end
    end

    task automatic report_field(string fname, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %s: expected %0h got %0h at %0t", fname, want, got, $time);
        end
    endtask

    // output side: beat check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (readings_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output beat at %0t", $time);
            end else begin
                t_reading w;
                w = readings_due.pop_front();
                if (o_temperature_centi !== w.tc)
                    report_field("temperature", 64'(16'(w.tc)), 64'(16'(o_temperature_centi)));
                if (o_pressure_q24_8 !== w.pres)
                    report_field("pressure", 64'(w.pres), 64'(o_pressure_q24_8));
                if (o_pressure_valid !== w.pv)
                    report_field("pressure_valid", 64'(w.pv), 64'(o_pressure_valid));
            end
        end
    end

    task automatic wait_idle();
        while (raw_backlog.size() != 0 || i_in_valid || readings_due.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIw-1:0] idx, logic [CfgW-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_TEMP:    coef_t = val;
            CFG_PRESS_A: coef_a = val;
            CFG_PRESS_B: coef_b = val;
            default:     coef_c = val;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_all(logic [CfgW-1:0] t, logic [CfgW-1:0] a, logic [CfgW-1:0] b,
                            logic [CfgW-1:0] c);
        write_reg(CFG_TEMP, t);
        write_reg(CFG_PRESS_A, a);
        write_reg(CFG_PRESS_B, b);
        write_reg(CFG_PRESS_C, c);
    endtask

    task automatic queue_beat(logic [RawW-1:0] rt, logic [RawW-1:0] rp);
        t_raw_pair it;
        it.rt = rt;
        it.rp = rp;
        raw_backlog.push_back(it);
    endtask

    function automatic logic [15:0] jitter(int base, int span);
        return 16'(base + $signed($urandom_range(0, 2 * span)) - span);
    endfunction

    initial begin
        logic [CfgW-1:0] nt, na, nb, nc;
        int r;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_raw_temperature = '0;
        i_raw_pressure = '0;
        i_out_stall = 1'b0;
        coef_t = '0;
        coef_a = '0;
        coef_b = '0;
        coef_c = '0;
        held_pres = '0;
        mismatches = 0;
        in_gap = 0;
        out_hold = 0;
        calm = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset coefficients: zero divisor, held value repeats
        queue_beat(20'd519888, 20'd415148);
        queue_beat(20'hfffff, 20'h00000);
        wait_idle();

        nt = pack3(16'd27504, 16'd26435, -16'sd1000);
        na = pack3(16'd36477, -16'sd10685, 16'd3024);
        nb = pack3(16'd2855, 16'd140, -16'sd7);
        nc = pack3(16'd15500, -16'sd14600, 16'd6000);
        load_all(nt, na, nb, nc);
        queue_beat(20'd519888, 20'd415148);
        queue_beat(20'h00000, 20'h00000);
        queue_beat(20'hfffff, 20'hfffff);
        queue_beat(20'h00000, 20'hfffff);
        queue_beat(20'hfffff, 20'h00000);
        queue_beat(20'h80000, 20'h7ffff);
        wait_idle();

        // P1 zero after a valid pressure: last value repeats
        write_reg(CFG_PRESS_A, pack3(16'd0, -16'sd10685, 16'd3024));
        queue_beat(20'd519888, 20'd300000);
        queue_beat(20'h12345, 20'h54321);
        wait_idle();

        // divisor term G zero: fine temperature at -920576, P3 at its minimum
        load_all(pack3(16'd57536, 16'd16384, 16'd0), pack3(16'd1, 16'd0, 16'h8000), nb, nc);
        queue_beat(20'd0, 20'd415148);
        queue_beat(20'd1, 20'd415148);
        wait_idle();

        // extremes: all ones, then large magnitude coefficients and tiny P1
        load_all({CfgW{1'b1}}, {CfgW{1'b1}}, {CfgW{1'b1}}, {CfgW{1'b1}});
        queue_beat(20'h00000, 20'h00000);
        queue_beat(20'hfffff, 20'hfffff);
        wait_idle();
        load_all(pack3(16'hffff, 16'h7fff, 16'h7fff), pack3(16'd1, 16'h8000, 16'h8000),
                 pack3(16'h7fff, 16'h8000, 16'h7fff), pack3(16'h8000, 16'h7fff, 16'h8000));
        queue_beat(20'h00000, 20'h00000);
        queue_beat(20'hfffff, 20'hfffff);
        queue_beat(20'h7ffff, 20'h80000);
        wait_idle();
        load_all(nt, pack3(16'd1, 16'd0, 16'd0), pack3(16'h8000, 16'd0, 16'd0),
                 pack3(16'h8000, 16'h8000, 16'h8000));
        queue_beat(20'd519888, 20'hfffff);
        queue_beat(20'd519888, 20'h00000);
        wait_idle();

        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            r = $urandom_range(0, 9);
            calm = (ph % 4 == 3);
            if (r < 6) begin
                nt = pack3(jitter(27504, 3000), jitter(26435, 4000), jitter(-1000, 800));
                na = pack3(jitter(36477, 4000), jitter(-10685, 2000), jitter(3024, 800));
                nb = pack3(jitter(2855, 2000), jitter(140, 200), jitter(-7, 20));
                nc = pack3(jitter(15500, 3000), jitter(-14600, 3000), jitter(6000, 2000));
                if (r == 0) na[15:0] = '0;
            end else begin
                nt = CfgW'({$urandom(), $urandom()});
                na = CfgW'({$urandom(), $urandom()});
                nb = CfgW'({$urandom(), $urandom()});
                nc = CfgW'({$urandom(), $urandom()});
            end
            load_all(nt, na, nb, nc);
            for (int k = 0; k < 75; k++) begin
                if ($urandom_range(0, 9) < 7)
                    queue_beat(20'($urandom_range(380000, 650000)),
                               20'($urandom_range(200000, 650000)));
                else
                    queue_beat(20'($urandom()), 20'($urandom()));
            end
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("pressure_temp_compensation_top_tb: done, clean");
        end else begin
            $display("pressure_temp_compensation_top_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("pressure_temp_compensation_top_tb: done, errors");
        $finish;
    end

endmodule
